// ===== sv/lpht_pkg.sv =====
// Shared types, codes and sizing constants for the linear probing hash table.
`default_nettype none

package lpht_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int KEY_W           = 31;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic [3:0]       slot;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [3:0]       index;
    logic [KEY_W-1:0] value;
    logic             occupied;
  } out_word_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
  } slot_t;

endpackage

`default_nettype wire

// ===== sv/lpht_mod.sv =====
// Remainder unit: key modulo the table size by reciprocal multiplication in three steps.
`default_nettype none

module lpht_mod #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              go,
  input  wire logic [lpht_pkg::KEY_W-1:0]        key,
  output logic                                   done,
  output logic [$clog2(TABLE_SLOTS)-1:0]         rem
);

  localparam int RW = $clog2(TABLE_SLOTS);
  localparam int KW = lpht_pkg::KEY_W;
  // With the reciprocal rounded down, the quotient estimate is exact or one short.
  localparam logic [KW-1:0] RECIP = KW'((64'd1 << KW) / 64'(TABLE_SLOTS));
  localparam logic [RW:0]   SLOTS = (RW+1)'(TABLE_SLOTS);

  logic                key_vld_r;
  logic                q_vld_r;
  logic                r0_vld_r;
  logic                done_r;
  logic [KW-1:0]       key_r;
  logic [2*KW-1:0]     prod;
  logic [KW-1:0]       q_r;
  logic [RW:0]         qn_lo;
  logic [RW:0]         r0_r;
  logic [RW-1:0]       rem_r;

  assign prod  = (2*KW)'(key_r) * (2*KW)'(RECIP);
  // The true difference is below twice the table size, so the low bits suffice.
  assign qn_lo = q_r[RW:0] * SLOTS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r <= 1'b0;
      q_vld_r   <= 1'b0;
      r0_vld_r  <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      key_vld_r <= go;
      q_vld_r   <= key_vld_r;
      r0_vld_r  <= q_vld_r;
      done_r    <= r0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      key_r <= key;
    end
    q_r   <= prod[2*KW-1:KW];
    r0_r  <= key_r[RW:0] - qn_lo;
    rem_r <= (r0_r >= SLOTS) ? RW'(r0_r - SLOTS) : r0_r[RW-1:0];
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== sv/lpht_ram.sv =====
// Slot memory: one write port, one read port with registered read data.
`default_nettype none

module lpht_ram #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(TABLE_SLOTS)-1:0]    wr_addr,
  input  wire lpht_pkg::slot_t                   wr_data,
  input  wire logic [$clog2(TABLE_SLOTS)-1:0]    rd_addr,
  output lpht_pkg::slot_t                        rd_data
);

  lpht_pkg::slot_t mem [TABLE_SLOTS];
  lpht_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/linear_probe_hash_table_top.sv =====
// Top level: linear probing hash table with a sequencer around one slot memory.
// After reset the block clears every slot, one per cycle, holding busy high while
// it does. Insert and search hash the key and read the home slot, then probe the
// slots in turn; an in-range slot read passes through a read state, while an
// out-of-range slot read or unused kind is answered straight from idle.
// The receiver cannot stall; idle again at the strobe.
`default_nettype none

module linear_probe_hash_table_top #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire lpht_pkg::in_word_t    in_data,
  output logic                       out_valid,
  output lpht_pkg::out_word_t        out_data
);

  localparam int AW = $clog2(TABLE_SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_READ
  } state_t;

  state_t                 state_r;
  lpht_pkg::in_word_t     item_r;
  logic [AW-1:0]          p_r;
  logic [AW-1:0]          p_nxt;
  logic [AW-1:0]          cnt_r;
  logic [AW-1:0]          clr_r;
  logic                   out_valid_r;
  lpht_pkg::out_word_t    out_word_r;

  logic                   mod_go;
  logic                   mod_done;
  logic [AW-1:0]          mod_rem;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  lpht_pkg::slot_t        wr_data;
  logic [AW-1:0]          rd_addr;
  lpht_pkg::slot_t        rd_data;

  logic [AW+3:0]          in_slot_ext;
  logic [AW+3:0]          item_slot_ext;
  logic [AW+3:0]          p_ext;
  logic                   in_slot_ok;
  logic                   is_insert;
  logic                   hit;
  logic                   last_probe;

  assign in_slot_ext   = {{AW{1'b0}}, in_data.slot};
  assign item_slot_ext = {{AW{1'b0}}, item_r.slot};
  assign p_ext         = {4'b0000, p_r};
  assign in_slot_ok    = in_slot_ext < (AW+4)'(TABLE_SLOTS);
  assign is_insert     = item_r.kind == lpht_pkg::KIND_INSERT;
  assign p_nxt         = (p_r == AW'(TABLE_SLOTS - 1)) ? '0 : p_r + AW'(1);
  assign last_probe    = cnt_r == AW'(TABLE_SLOTS - 1);

  // An insert stops at the first empty slot, a search at the first valid match.
  assign hit = is_insert ? !rd_data.vld : (rd_data.vld && rd_data.key == item_r.key);

  assign busy   = (state_r != S_IDLE) || !rst_n;
  assign mod_go = (state_r == S_IDLE) && start && rst_n &&
                  (in_data.kind == lpht_pkg::KIND_INSERT ||
                   in_data.kind == lpht_pkg::KIND_SEARCH);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_r;
    wr_data = '{vld: 1'b1, key: item_r.key};
    rd_addr = '0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
      end
      S_IDLE: begin
        rd_addr = in_slot_ext[AW-1:0];
      end
      S_HASH: begin
        rd_addr = mod_rem;
      end
      S_PROBE: begin
        // Next slot is read while the current one is checked; the write of an
        // insert ends the walk, so it never meets a read of the same slot.
        rd_addr = p_nxt;
        wr_en   = is_insert && !rd_data.vld;
      end
      S_READ: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(TABLE_SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            item_r <= in_data;
            priority if (mod_go) begin
              state_r <= S_HASH;
            end else if (in_data.kind == lpht_pkg::KIND_READ) begin
              if (in_slot_ok) begin
                state_r <= S_READ;
              end else begin
                out_valid_r <= 1'b1;
                out_word_r  <= '{status: lpht_pkg::ST_READ, index: in_data.slot,
                                 value: '0, occupied: 1'b0};
              end
            end else begin
              out_valid_r <= 1'b1;
              out_word_r  <= '{status: lpht_pkg::ST_NOTFOUND, index: '0,
                               value: '0, occupied: 1'b0};
            end
          end
        end
        S_HASH: begin
          if (mod_done) begin
            p_r     <= mod_rem;
            cnt_r   <= '0;
            state_r <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (hit) begin
            out_valid_r <= 1'b1;
            out_word_r  <= '{status: is_insert ? lpht_pkg::ST_INSERTED : lpht_pkg::ST_FOUND,
                             index: p_ext[3:0], value: '0, occupied: 1'b0};
            state_r     <= S_IDLE;
          end else if (last_probe) begin
            out_valid_r <= 1'b1;
            out_word_r  <= '{status: is_insert ? lpht_pkg::ST_FULL : lpht_pkg::ST_NOTFOUND,
                             index: '0, value: '0, occupied: 1'b0};
            state_r     <= S_IDLE;
          end else begin
            p_r   <= p_nxt;
            cnt_r <= cnt_r + AW'(1);
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          out_word_r  <= '{status: lpht_pkg::ST_READ, index: item_slot_ext[3:0],
                           value: rd_data.vld ? rd_data.key : '0,
                           occupied: rd_data.vld};
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  lpht_mod #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mod_go),
    .key   (in_data.key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  lpht_ram #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// ===== sv/lpht_chk.sv =====
// Port-level checker for the hash table top level, bound to every instance.
`default_nettype none

module lpht_chk (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire lpht_pkg::out_word_t  out_data,
  input wire logic                 out_valid
);

  // The block stays busy while it clears the table after reset.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

  // A word is only strobed as the block returns to idle.
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word strobed while busy");

  // Every accepted word either starts work or answers on the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted word neither started nor answered");

  // Probe results carry no slot contents.
  a_probe_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != lpht_pkg::ST_READ
      |-> out_data.value == '0 && !out_data.occupied)
    else $error("probe result carries slot contents");

  // An empty slot reads as zero, and status stays within its codes.
  a_read_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= lpht_pkg::ST_READ &&
      (out_data.occupied || out_data.value == '0))
    else $error("bad status or nonzero value from an empty slot");

endmodule

bind linear_probe_hash_table_top lpht_chk u_lpht_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);

`default_nettype wire

// ===== test/linear_probe_hash_table_top_tb.sv =====
// Self-checking testbench for the linear probing hash table: directed and random bursty commands.
`timescale 1ns / 100ps

module linear_probe_hash_table_top_tb;

  localparam int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 900;

  logic                logic_dummy_unused_guard;
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  lpht_pkg::in_word_t  in_data = '0;
  logic                busy;
  logic                out_valid;
  lpht_pkg::out_word_t out_data;

  lpht_pkg::in_word_t            pending_items [$];
  lpht_pkg::out_word_t           expected_answers [$];
  logic [lpht_pkg::KEY_W-1:0]    inserted_keys [$];

  // Shadow copy of the table contents.
  logic [lpht_pkg::KEY_W-1:0] held_keys [TABLE_SLOTS];
  bit                         slot_used [TABLE_SLOTS] = '{default: 1'b0};

  int unsigned error_count = 0;
  int unsigned accepted_count = 0;
  int unsigned status_seen [8] = '{default: 0};
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  assign logic_dummy_unused_guard = 1'b0;

  linear_probe_hash_table_top #(.TABLE_SLOTS(TABLE_SLOTS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one command word to the shadow table and returns the answer it must give.
  function automatic lpht_pkg::out_word_t apply_to_table(lpht_pkg::in_word_t w);
    lpht_pkg::out_word_t r;
    int unsigned         home;
    int unsigned         p;
    int                  i;
    bit                  done;
    r = '0;
    done = 1'b0;
    home = w.key % TABLE_SLOTS;
    case (w.kind)
      lpht_pkg::KIND_INSERT: begin
        r.status = lpht_pkg::ST_FULL;
        for (i = 0; i < TABLE_SLOTS && !done; i++) begin
          p = (home + i) % TABLE_SLOTS;
          if (!slot_used[p]) begin
            held_keys[p] = w.key;
            slot_used[p] = 1'b1;
            r.status = lpht_pkg::ST_INSERTED;
            r.index = 4'(p);
            done = 1'b1;
          end
        end
      end
      lpht_pkg::KIND_SEARCH: begin
        r.status = lpht_pkg::ST_NOTFOUND;
        for (i = 0; i < TABLE_SLOTS && !done; i++) begin
          p = (home + i) % TABLE_SLOTS;
          if (slot_used[p] && held_keys[p] == w.key) begin
            r.status = lpht_pkg::ST_FOUND;
            r.index = 4'(p);
            done = 1'b1;
          end
        end
      end
      lpht_pkg::KIND_READ: begin
        r.status = lpht_pkg::ST_READ;
        r.index = w.slot;
        if (int'(w.slot) < TABLE_SLOTS && slot_used[w.slot]) begin
          r.value = held_keys[w.slot];
          r.occupied = 1'b1;
        end
      end
      default: r.status = lpht_pkg::ST_NOTFOUND;
    endcase
    return r;
  endfunction

  function automatic void queue_item(logic [1:0] kind, logic [lpht_pkg::KEY_W-1:0] key,
                                     logic [3:0] slot);
    lpht_pkg::in_word_t w;
    w.kind = kind;
    w.key = key;
    w.slot = slot;
    pending_items.push_back(w);
    if (kind == lpht_pkg::KIND_INSERT) inserted_keys.push_back(key);
  endfunction

  function automatic logic [lpht_pkg::KEY_W-1:0] rand_key();
    return lpht_pkg::KEY_W'($urandom);
  endfunction

  function automatic logic [lpht_pkg::KEY_W-1:0] some_inserted_key();
    return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
  endfunction

  // Command driver: bursts of words separated by random gaps, noise on the bus during the gaps.
  always @(posedge clk) begin
    lpht_pkg::in_word_t next_word;
    logic               next_start;
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 12);
      gap_left = 0;
    end else begin
      next_start = start;
      next_word = in_data;
      if (start && !busy) begin
        expected_answers.push_back(apply_to_table(pending_items.pop_front()));
        accepted_count++;
        next_start = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
          next_word.kind = 2'($urandom_range(0, 3));
          next_word.key = rand_key();
          next_word.slot = 4'($urandom_range(0, 15));
        end else if (pending_items.size() != 0) begin
          next_start = 1'b1;
          next_word = pending_items[0];
        end
      end
      start <= next_start;
      in_data <= next_word;
    end
  end

  // Result monitor: every strobed word must match the oldest prediction.
  always @(posedge clk) begin
    lpht_pkg::out_word_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result word: %p", out_data);
        error_count++;
      end else begin
        want = expected_answers.pop_front();
        status_seen[want.status]++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.index !== want.index) begin
          $error("index: expected %0d, got %0d", want.index, out_data.index);
          error_count++;
        end
        if (out_data.value !== want.value) begin
          $error("value: expected %0h, got %0h", want.value, out_data.value);
          error_count++;
        end
        if (out_data.occupied !== want.occupied) begin
          $error("occupied: expected %0b, got %0b", want.occupied, out_data.occupied);
          error_count++;
        end
      end
    end
  end

  initial begin
    int                         r;
    int                         i;
    logic [lpht_pkg::KEY_W-1:0] k;

    // Directed: empty table, key zero, largest key, wrap-around, duplicates, unused kind.
    queue_item(lpht_pkg::KIND_SEARCH, 31'd5, 4'd0);
    queue_item(lpht_pkg::KIND_READ, 31'd0, 4'd0);
    queue_item(lpht_pkg::KIND_READ, 31'd0, 4'd15);
    queue_item(lpht_pkg::KIND_INSERT, 31'd0, 4'd0);
    queue_item(lpht_pkg::KIND_SEARCH, 31'd0, 4'd0);
    queue_item(lpht_pkg::KIND_INSERT, 31'h7FFF_FFFF, 4'd0);
    queue_item(lpht_pkg::KIND_INSERT, 31'd31, 4'd0);
    queue_item(lpht_pkg::KIND_INSERT, 31'd31, 4'd0);
    queue_item(lpht_pkg::KIND_SEARCH, 31'd31, 4'd0);
    queue_item(lpht_pkg::KIND_SEARCH, 31'h7FFF_FFFF, 4'd0);
    queue_item(lpht_pkg::KIND_READ, 31'd0, 4'd15);
    queue_item(lpht_pkg::KIND_READ, 31'd0, 4'd1);
    queue_item(lpht_pkg::KIND_READ, 31'd0, 4'd2);
    queue_item(KIND_UNUSED, 31'h5555_5555, 4'hA);
    queue_item(KIND_UNUSED, 31'h7FFF_FFFF, 4'hF);
    queue_item(lpht_pkg::KIND_SEARCH, 31'd47, 4'd0);
    queue_item(lpht_pkg::KIND_INSERT, 31'd16, 4'd0);
    queue_item(lpht_pkg::KIND_SEARCH, 31'd16, 4'd0);
    queue_item(lpht_pkg::KIND_READ, 31'h2AAA_AAAA, 4'd4);
    queue_item(lpht_pkg::KIND_SEARCH, 31'h2AAA_AAAA, 4'h5);

    // Random: mostly lookups against a table that slowly fills, inserts kept rare
    // so that the partly filled table is exercised before it saturates.
    for (i = 0; i < RANDOM_WORDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        if ($urandom_range(0, 1) == 0) k = rand_key();
        else k = (rand_key() & ~31'hF) | lpht_pkg::KEY_W'($urandom_range(12, 15));
        queue_item(lpht_pkg::KIND_INSERT, k, 4'($urandom_range(0, 15)));
      end else if (r < 52) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: k = some_inserted_key();
          5, 6: k = some_inserted_key() ^
                    (lpht_pkg::KEY_W'(1) << $urandom_range(4, lpht_pkg::KEY_W - 1));
          default: k = rand_key();
        endcase
        queue_item(lpht_pkg::KIND_SEARCH, k, 4'($urandom_range(0, 15)));
      end else if (r < 92) begin
        queue_item(lpht_pkg::KIND_READ, rand_key(), 4'($urandom_range(0, 15)));
      end else begin
        queue_item(KIND_UNUSED, rand_key(), 4'($urandom_range(0, 15)));
      end
    end

    // Make sure the table ends up full, then probe it completely.
    for (i = 0; i < TABLE_SLOTS + 2; i++) queue_item(lpht_pkg::KIND_INSERT, rand_key(), 4'd0);
    for (i = 0; i < 6; i++) begin
      queue_item(lpht_pkg::KIND_SEARCH, some_inserted_key(), 4'd0);
      queue_item(lpht_pkg::KIND_SEARCH, rand_key(), 4'd0);
    end
    for (i = 0; i < TABLE_SLOTS; i++) queue_item(lpht_pkg::KIND_READ, rand_key(), 4'(i));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || start || expected_answers.size() != 0)
      @(posedge clk);
    repeat (TABLE_SLOTS + 12) @(posedge clk);

    $display("Accepted %0d command words against a %0d-slot table.", accepted_count,
             TABLE_SLOTS);
    $display("Answers: %0d inserted, %0d full, %0d found, %0d not found, %0d slot reads.",
             status_seen[lpht_pkg::ST_INSERTED], status_seen[lpht_pkg::ST_FULL],
             status_seen[lpht_pkg::ST_FOUND], status_seen[lpht_pkg::ST_NOTFOUND],
             status_seen[lpht_pkg::ST_READ]);
    if (error_count == 0 && !logic_dummy_unused_guard) begin
      $display("linear_probe_hash_table_top_tb OK");
    end else begin
      $display("linear_probe_hash_table_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d words pending and %0d answers outstanding.",
             pending_items.size(), expected_answers.size());
    $display("linear_probe_hash_table_top_tb NOT OK");
    $finish;
  end

endmodule
